/* rtl/core/ptp_pkg.sv */
// Shared types and constants for the picture tile partitioner.
// Holds layout codes, the region plan struct and the layout decoder.
// Depends on nothing.
package ptp_pkg;

  localparam logic [2:0] LAYOUT_SINGLE         = 3'd0;
  localparam logic [2:0] LAYOUT_ONE_BY_TWO     = 3'd1;
  localparam logic [2:0] LAYOUT_THREE_BY_ONE   = 3'd2;
  localparam logic [2:0] LAYOUT_TWO_BY_TWO     = 3'd3;
  localparam logic [2:0] LAYOUT_THREE_OVER_TWO = 3'd4;
  localparam logic [2:0] LAYOUT_THREE_BY_TWO   = 3'd5;

  localparam int MIN_WIDTH  = 48;
  localparam int MIN_HEIGHT = 32;

  // Error flag, column counts of the two rows and the total region count.
  typedef struct packed {
    logic       bad;
    logic [1:0] top_cols;
    logic [1:0] bot_cols;
    logic [2:0] count;
  } plan_t;

  function automatic plan_t decode_plan(input logic [2:0] layout, input logic dims_bad);
    plan_t p;
    p = '0;
    unique case (layout)
      LAYOUT_SINGLE:         begin p.top_cols = 2'd1; p.bot_cols = 2'd0; p.count = 3'd1; end
      LAYOUT_ONE_BY_TWO:     begin p.top_cols = 2'd1; p.bot_cols = 2'd1; p.count = 3'd2; end
      LAYOUT_THREE_BY_ONE:   begin p.top_cols = 2'd3; p.bot_cols = 2'd0; p.count = 3'd3; end
      LAYOUT_TWO_BY_TWO:     begin p.top_cols = 2'd2; p.bot_cols = 2'd2; p.count = 3'd4; end
      LAYOUT_THREE_OVER_TWO: begin p.top_cols = 2'd3; p.bot_cols = 2'd2; p.count = 3'd5; end
      LAYOUT_THREE_BY_TWO:   begin p.top_cols = 2'd3; p.bot_cols = 2'd3; p.count = 3'd6; end
      default:               p.bad = 1'b1;
    endcase
    if (dims_bad || p.bad) begin
      p = '0;
      p.bad = 1'b1;
    end
    return p;
  endfunction

endpackage

/* rtl/core/picture_tile_partitioner.sv */
// Flow: a taken request passes the setup stages 1 to 3 into the emitter, which
// then yields one registered result per cycle, 1 to 6 results (one for an error).
// Throughput: the emitter's single result port takes a new plan only on the last region;
// the three setup stages take a request every cycle until they back up behind it.
// Reset: synchronous rst clears all stage valid bits and the result strobe.
// The receiver cannot stall; busy only reflects the pipeline backing up.
module picture_tile_partitioner
  import ptp_pkg::*;
#(
  parameter int DIM_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          layout,
  input  logic [DIM_BITS-1:0] picture_width,
  input  logic [DIM_BITS-1:0] picture_height,
  output logic                result_valid,
  output logic [2:0]          worker_id,
  output logic [DIM_BITS-1:0] region_x,
  output logic [DIM_BITS-1:0] region_y,
  output logic [DIM_BITS-1:0] region_width,
  output logic [DIM_BITS-1:0] region_height,
  output logic [2:0]          region_count,
  output logic                last_region,
  output logic                bad_request
);

  // Width in 16-pixel units; a third is floor(units/3)*16.
  // floor(v/3) = (v * ceil(2^(N+1)/3)) >> (N+1), exact for v < 2^N.
  localparam int N = DIM_BITS - 4;
  localparam logic [N-1:0] RECIP3 = N'(((2 ** (N + 1)) + 2) / 3);

  logic accept;
  logic s1_ready, s2_ready, s3_ready, e_take;

  // Stage 1: capture the request and check dimensions.
  logic                s1_valid;
  logic [2:0]          s1_layout;
  logic [DIM_BITS-1:0] s1_pw, s1_ph;
  logic                s1_dims_bad;

  // Stage 2: decode the layout, form halves, start the divide by three.
  logic                s2_valid;
  plan_t               s2_plan;
  logic [DIM_BITS-1:0] s2_pw, s2_ph, s2_half_w, s2_half_h;
  logic [2*N-1:0]      s2_prod;

  // Stage 3: finish the thirds.
  logic                s3_valid;
  plan_t               s3_plan;
  logic [DIM_BITS-1:0] s3_pw, s3_ph, s3_half_w, s3_half_h, s3_third_w, s3_two_third;

  logic [N-2:0]        quot;

  // Each stage advances when the one after it frees up.
  assign s3_ready = !s3_valid || e_take;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign busy     = !s1_ready;
  assign accept   = start && !busy;
  assign quot     = s2_prod[2*N-1:N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= accept;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end

    if (accept) begin
      s1_layout   <= layout;
      s1_pw       <= picture_width;
      s1_ph       <= picture_height;
      s1_dims_bad <= (picture_width < DIM_BITS'(MIN_WIDTH))
                  || (picture_height < DIM_BITS'(MIN_HEIGHT))
                  || (picture_width[3:0] != 4'd0)
                  || (picture_height[3:0] != 4'd0);
    end

    if (s2_ready && s1_valid) begin
      s2_plan   <= decode_plan(s1_layout, s1_dims_bad);
      s2_pw     <= s1_pw;
      s2_ph     <= s1_ph;
      s2_half_w <= {1'b0, s1_pw[DIM_BITS-1:5], 4'b0000};
      s2_half_h <= {1'b0, s1_ph[DIM_BITS-1:5], 4'b0000};
      s2_prod   <= (2*N)'(s1_pw[DIM_BITS-1:4]) * (2*N)'(RECIP3);
    end

    if (s3_ready && s2_valid) begin
      s3_plan      <= s2_plan;
      s3_pw        <= s2_pw;
      s3_ph        <= s2_ph;
      s3_half_w    <= s2_half_w;
      s3_half_h    <= s2_half_h;
      s3_third_w   <= {1'b0, quot, 4'b0000};
      s3_two_third <= {quot, 5'b00000};
    end
  end

  // Walk the regions of each plan and drive the result ports.
  ptp_emitter #(
    .DIM_BITS(DIM_BITS)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .plan         (s3_plan),
    .pw           (s3_pw),
    .ph           (s3_ph),
    .half_w       (s3_half_w),
    .half_h       (s3_half_h),
    .third_w      (s3_third_w),
    .two_third    (s3_two_third),
    .take         (e_take),
    .result_valid (result_valid),
    .worker_id    (worker_id),
    .region_x     (region_x),
    .region_y     (region_y),
    .region_width (region_width),
    .region_height(region_height),
    .region_count (region_count),
    .last_region  (last_region),
    .bad_request  (bad_request)
  );

endmodule

/* rtl/core/ptp_emitter.sv */
// Region emitter: walks the regions of one plan, one result per cycle.
// Depends on ptp_pkg (plan_t).
module ptp_emitter
  import ptp_pkg::*;
#(
  parameter int DIM_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  plan_t               plan,
  input  logic [DIM_BITS-1:0] pw,
  input  logic [DIM_BITS-1:0] ph,
  input  logic [DIM_BITS-1:0] half_w,
  input  logic [DIM_BITS-1:0] half_h,
  input  logic [DIM_BITS-1:0] third_w,
  input  logic [DIM_BITS-1:0] two_third,
  output logic                take,
  output logic                result_valid,
  output logic [2:0]          worker_id,
  output logic [DIM_BITS-1:0] region_x,
  output logic [DIM_BITS-1:0] region_y,
  output logic [DIM_BITS-1:0] region_width,
  output logic [DIM_BITS-1:0] region_height,
  output logic [2:0]          region_count,
  output logic                last_region,
  output logic                bad_request
);

  logic                active;
  logic                row;
  logic [1:0]          col;
  logic [2:0]          idx;
  plan_t               cur;
  logic [DIM_BITS-1:0] c_pw, c_ph, c_half_w, c_half_h, c_third_w, c_two_third;

  logic [1:0]          cols;
  logic [DIM_BITS-1:0] mid, x0, x1, y0, y1;
  logic                last_col, emit_last;

  always_comb begin
    cols      = row ? cur.bot_cols : cur.top_cols;
    mid       = (cols == 2'd2) ? c_half_w : c_third_w;
    last_col  = (col == 2'(cols - 2'd1));
    x0        = (col == 2'd0) ? '0 : ((col == 2'd1) ? mid : c_two_third);
    x1        = last_col ? c_pw : ((col == 2'd0) ? mid : c_two_third);
    y0        = row ? c_half_h : '0;
    y1        = (row || cur.bot_cols == 2'd0) ? c_ph : c_half_h;
    emit_last = active && (cur.bad || 3'(idx + 3'd1) == cur.count);
    take      = !active || emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      active <= in_valid;
    end
    if (take) begin
      cur         <= plan;
      c_pw        <= pw;
      c_ph        <= ph;
      c_half_w    <= half_w;
      c_half_h    <= half_h;
      c_third_w   <= third_w;
      c_two_third <= two_third;
      row         <= 1'b0;
      col         <= 2'd0;
      idx         <= 3'd0;
    end else if (active) begin
      idx <= 3'(idx + 3'd1);
      if (last_col) begin
        row <= 1'b1;
        col <= 2'd0;
      end else begin
        col <= 2'(col + 2'd1);
      end
    end
  end

  // Register the result; bad requests carry zero fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= active;
    end
    last_region <= emit_last;
    bad_request <= cur.bad;
    if (cur.bad) begin
      worker_id     <= 3'd0;
      region_x      <= '0;
      region_y      <= '0;
      region_width  <= '0;
      region_height <= '0;
      region_count  <= 3'd0;
    end else begin
      worker_id     <= idx;
      region_x      <= x0;
      region_y      <= y0;
      region_width  <= x1 - x0;
      region_height <= y1 - y0;
      region_count  <= cur.count;
    end
  end

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_region |=> result_valid)
    else $error("gap inside a region burst");

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_region |=> worker_id == 3'($past(worker_id) + 3'd1))
    else $error("worker id did not advance by one");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_request |-> last_region && region_count == 3'd0)
    else $error("error result not a single zeroed transaction");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && !bad_request && last_region |->
      region_count == 3'(worker_id + 3'd1))
    else $error("last region does not match region count");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for picture_tile_partitioner: directed and random partition
// requests, region plans predicted in-bench and compared against every result strobe.
// Depends on ptp_pkg (layout codes, minimum dimensions) and the partitioner RTL.
module tb_top
  import ptp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_BITS   = 12;
  localparam int TILE       = 16;   // macroblock edge, dimensions must be multiples
  localparam int HALF_DIV   = 32;   // half = floor(dim/32)*16
  localparam int THIRD_DIV  = 48;   // third = floor(width/48)*16
  localparam int IDLE_LIMIT = 2000; // cycles with no transaction before giving up
  localparam int DRAIN_WAIT = 20;   // quiet cycles after the last expected region
  localparam int RANDOM_REQS = 286;

  // Layout codes the block must reject.
  localparam logic [2:0] LAYOUT_RESERVED_LO = 3'd6;
  localparam logic [2:0] LAYOUT_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0]          layout;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    int                  gap;     // idle cycles after this request is taken
  } request_t;

  typedef struct packed {
    logic [2:0]          worker_id;
    logic [DIM_BITS-1:0] region_x;
    logic [DIM_BITS-1:0] region_y;
    logic [DIM_BITS-1:0] region_width;
    logic [DIM_BITS-1:0] region_height;
    logic [2:0]          region_count;
    logic                last_region;
    logic                bad_request;
  } region_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          layout = '0;
  logic [DIM_BITS-1:0] picture_width = '0;
  logic [DIM_BITS-1:0] picture_height = '0;
  logic                result_valid;
  logic [2:0]          worker_id;
  logic [DIM_BITS-1:0] region_x;
  logic [DIM_BITS-1:0] region_y;
  logic [DIM_BITS-1:0] region_width;
  logic [DIM_BITS-1:0] region_height;
  logic [2:0]          region_count;
  logic                last_region;
  logic                bad_request;

  request_t request_q[$];   // requests still to be driven
  region_t  region_q[$];    // regions predicted but not yet seen

  int  total_reqs = 0;
  int  taken_reqs = 0;
  int  fault_count = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  cur_gap = 0;
  bit  took_req = 1'b0;     // set at the rising edge that accepted a request

  picture_tile_partitioner #(
    .DIM_BITS(DIM_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .layout        (layout),
    .picture_width (picture_width),
    .picture_height(picture_height),
    .result_valid  (result_valid),
    .worker_id     (worker_id),
    .region_x      (region_x),
    .region_y      (region_y),
    .region_width  (region_width),
    .region_height (region_height),
    .region_count  (region_count),
    .last_region   (last_region),
    .bad_request   (bad_request)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Left edge of column i in a row split into cols columns; the last column
  // ends at the picture edge and so absorbs the remainder.
  function automatic int column_edge(input int cols, input int i, input int w);
    if (i == 0) return 0;
    if (i == cols) return w;
    if (cols == 2) return (w / HALF_DIV) * TILE;
    return i * ((w / THIRD_DIV) * TILE);
  endfunction

  // Predict the region plan for one accepted request and queue it in worker order.
  task automatic plan_regions(input logic [2:0] lay, input int w, input int h);
    int      top_cols;
    int      bot_cols;
    int      rows;
    int      cols;
    int      id;
    int      y0;
    int      y1;
    int      half_h;
    region_t r;
    r = '0;
    if (w < MIN_WIDTH || h < MIN_HEIGHT || (w % TILE) != 0 || (h % TILE) != 0 ||
        lay > LAYOUT_THREE_BY_TWO) begin
      // Rejected request: one result, everything zero but the two marks.
      r.last_region = 1'b1;
      r.bad_request = 1'b1;
      region_q.push_back(r);
      return;
    end
    case (lay)
      LAYOUT_SINGLE: begin
        top_cols = 1; bot_cols = 0;
      end
      LAYOUT_ONE_BY_TWO: begin
        top_cols = 1; bot_cols = 1;
      end
      LAYOUT_THREE_BY_ONE: begin
        top_cols = 3; bot_cols = 0;
      end
      LAYOUT_TWO_BY_TWO: begin
        top_cols = 2; bot_cols = 2;
      end
      LAYOUT_THREE_OVER_TWO: begin
        top_cols = 3; bot_cols = 2;
      end
      default: begin
        top_cols = 3; bot_cols = 3;
      end
    endcase
    rows = (bot_cols == 0) ? 1 : 2;
    half_h = (h / HALF_DIV) * TILE;
    id = 0;
    for (int row = 0; row < rows; row++) begin
      cols = (row == 0) ? top_cols : bot_cols;
      y0 = (row == 0) ? 0 : half_h;
      y1 = (rows == 2 && row == 0) ? half_h : h;
      for (int col = 0; col < cols; col++) begin
        r.worker_id     = 3'(id);
        r.region_x      = DIM_BITS'(column_edge(cols, col, w));
        r.region_y      = DIM_BITS'(y0);
        r.region_width  = DIM_BITS'(column_edge(cols, col + 1, w) - column_edge(cols, col, w));
        r.region_height = DIM_BITS'(y1 - y0);
        r.region_count  = 3'(top_cols + bot_cols);
        r.last_region   = (id + 1 == top_cols + bot_cols);
        r.bad_request   = 1'b0;
        region_q.push_back(r);
        id++;
      end
    end
  endtask

  task automatic add_request(input logic [2:0] lay, input int w, input int h,
                             input int gap);
    request_t q;
    q.layout = lay;
    q.width  = DIM_BITS'(w);
    q.height = DIM_BITS'(h);
    q.gap    = gap;
    request_q.push_back(q);
    total_reqs++;
  endtask

  // Idle length between requests: mostly back to back or short, a few long.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Driver: present requests at the falling edge, hold each one until the
  // rising edge that takes it, then honor the idle gap attached to it.
  always @(negedge clk) begin : driver
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took_req) begin
      // hold: the block has not taken the current request yet
    end else begin
      if (start && took_req) gap_left = cur_gap;
      if (gap_left != 0 || request_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        start          <= 1'b0;
        // Scramble the payload while idle; the block must ignore it.
        layout         <= 3'($urandom_range(0, 7));
        picture_width  <= DIM_BITS'($urandom_range(0, 4095));
        picture_height <= DIM_BITS'($urandom_range(0, 4095));
      end else begin
        nxt = request_q.pop_front();
        start          <= 1'b1;
        layout         <= nxt.layout;
        picture_width  <= nxt.width;
        picture_height <= nxt.height;
        cur_gap        = nxt.gap;
      end
    end
  end

  // Monitor: take note of accepted requests, check every region strobe against
  // the oldest prediction, and run the no-progress watchdog.
  always @(posedge clk) begin : monitor
    region_t got;
    region_t exp;
    took_req = !rst && start && !busy;
    if (took_req) begin
      plan_regions(layout, int'(picture_width), int'(picture_height));
      taken_reqs++;
    end
    if (!rst && result_valid) begin
      got = {worker_id, region_x, region_y, region_width, region_height,
             region_count, last_region, bad_request};
      if (region_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] unexpected region: id=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d last=%0b bad=%0b",
                   $realtime, got.worker_id, got.region_x, got.region_y, got.region_width,
                   got.region_height, got.region_count, got.last_region, got.bad_request);
      end else begin
        exp = region_q.pop_front();
        if (got !== exp) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("[%0t] region mismatch", $realtime);
            $display("  expected: id=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d last=%0b bad=%0b",
                     exp.worker_id, exp.region_x, exp.region_y, exp.region_width,
                     exp.region_height, exp.region_count, exp.last_region, exp.bad_request);
            $display("  actual:   id=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d last=%0b bad=%0b",
                     got.worker_id, got.region_x, got.region_y, got.region_width,
                     got.region_height, got.region_count, got.last_region, got.bad_request);
          end
        end
      end
    end
    // Advance the watchdog only while the block is out of reset and nothing moves.
    if (rst || took_req || result_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit burst;
    int w;
    int h;
    // Every layout at the smallest legal picture, the first ones back to back.
    add_request(LAYOUT_SINGLE,         48, 32, 0);
    add_request(LAYOUT_ONE_BY_TWO,     48, 32, 0);
    add_request(LAYOUT_THREE_BY_ONE,   48, 32, 0);
    add_request(LAYOUT_TWO_BY_TWO,     48, 32, 0);
    add_request(LAYOUT_THREE_OVER_TWO, 48, 32, 1);
    add_request(LAYOUT_THREE_BY_TWO,   48, 32, 2);
    // Every layout at the largest legal picture.
    add_request(LAYOUT_SINGLE,         4080, 4080, 0);
    add_request(LAYOUT_ONE_BY_TWO,     4080, 4080, 0);
    add_request(LAYOUT_THREE_BY_ONE,   4080, 4080, 3);
    add_request(LAYOUT_TWO_BY_TWO,     4080, 4080, 0);
    add_request(LAYOUT_THREE_OVER_TWO, 4080, 4080, 0);
    add_request(LAYOUT_THREE_BY_TWO,   4080, 4080, 5);
    // Odd macroblock counts: last column and row take the larger remainder.
    add_request(LAYOUT_THREE_BY_TWO,   80, 48, 0);
    add_request(LAYOUT_THREE_OVER_TWO, 112, 80, 0);
    // Rejected requests: reserved layouts, too small, not aligned, all ones.
    add_request(LAYOUT_RESERVED_LO,    64, 64, 0);
    add_request(LAYOUT_RESERVED_HI,    64, 64, 0);
    add_request(LAYOUT_TWO_BY_TWO,     32, 64, 0);
    add_request(LAYOUT_TWO_BY_TWO,     64, 16, 0);
    add_request(LAYOUT_SINGLE,         50, 64, 1);
    add_request(LAYOUT_SINGLE,         64, 40, 0);
    add_request(LAYOUT_SINGLE,         0, 0, 0);
    add_request(LAYOUT_RESERVED_HI,    4095, 4095, 0);
    add_request(LAYOUT_THREE_BY_TWO,   4095, 4080, 0);
    // Then a long plan right after an error, at the minimum width.
    add_request(LAYOUT_THREE_BY_TWO,   48, 4080, 0);

    // Random part: mostly legal pictures, some raw noise. Mix stretches of
    // back-to-back requests with stretches of random idling.
    burst = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 80) begin
        w = TILE * $urandom_range(MIN_WIDTH / TILE, 255);
        h = TILE * $urandom_range(MIN_HEIGHT / TILE, 255);
        add_request(3'($urandom_range(0, 5)), w, h, burst ? 0 : random_gap());
      end else begin
        add_request(3'($urandom_range(0, 7)), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), burst ? 0 : random_gap());
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every request taken, every predicted region seen, then stay quiet.
    while (taken_reqs != total_reqs || region_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fault_count == 0 && region_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ptp_pkg.sv
rtl/core/ptp_emitter.sv
rtl/core/picture_tile_partitioner.sv
verif/tb_top.sv
